// ----- sv/pftbp_pkg.sv -----
// Package for the per-flow token bucket policer.
// Holds the command and result beat types, the field widths, codes and the FSM state type.
// No dependencies.
package pftbp_pkg;

    localparam int IDX_W   = 12;
    localparam int TS_W    = 64;
    localparam int LEN_W   = 16;
    localparam int PRIO_W  = 32;
    localparam int RATE_W  = 40;
    localparam int TOK_W   = 41;
    localparam int BITS_W  = LEN_W + 3;
    localparam int PROD_W  = 128;
    localparam int CNT_W   = 3;

    localparam logic CMD_PACKET   = 1'b0;
    localparam logic CMD_POLICY   = 1'b1;
    localparam logic VERDICT_PASS = 1'b0;
    localparam logic VERDICT_DROP = 1'b1;

    localparam logic [63:0] NS_PER_S = 64'd1000000000;

    // refill quotient at or above 2^41 exceeds any cap
    localparam logic [PROD_W-1:0] BIG_LIM = {64'd0, NS_PER_S} << TOK_W;

    // rate/10 = (rate/2)/5: multiply rate/2 (below 2^39) by ceil(2^42/5), keep bits 42 and up
    localparam int                CAP_SHIFT = 42;
    localparam logic [PROD_W-1:0] CAP_HALF  = 128'd5;
    localparam logic [63:0]       RCP_CAP   =
        64'(((128'd1 << CAP_SHIFT) + CAP_HALF - 128'd1) / CAP_HALF);

    // x/1e9 = (x/2^9)/5^9: multiply x/2^9 (below 2^62) by ceil(2^83/5^9), keep bits 83 and up
    localparam int                SEC_PRE   = 9;
    localparam int                SEC_SHIFT = 83;
    localparam logic [PROD_W-1:0] SEC_ODD   = {64'd0, NS_PER_S} >> SEC_PRE;
    localparam logic [63:0]       RCP_SEC   =
        64'(((128'd1 << SEC_SHIFT) + SEC_ODD - 128'd1) / SEC_ODD);

    localparam logic [CNT_W-1:0] MUL_LAST = 3'd4;

    typedef struct packed {
        logic              command;
        logic [IDX_W-1:0]  flow_index;
        logic [TS_W-1:0]   timestamp_ns;
        logic [LEN_W-1:0]  packet_length;
        logic [PRIO_W-1:0] new_priority;
        logic [RATE_W-1:0] new_rate_bps;
    } t_in;

    typedef struct packed {
        logic              verdict;
        logic              priority_set;
        logic [PRIO_W-1:0] priority_res;
    } t_out;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_CAP,
        ST_MUL,
        ST_DIV,
        ST_UPD
    } t_state;

endpackage

// ----- sv/per_flow_token_bucket_policer.sv -----
// Sequence: policy writes and packets that need no bucket give their result from ST_LOOK;
// a first packet of a flow goes ST_LOOK, ST_CAP, ST_UPD; a refill goes ST_LOOK, ST_CAP,
// ST_MUL, ST_DIV, ST_UPD, skipping ST_DIV when the refill product already exceeds any cap.
// One beat is taken at a time; the 32x32 multiplier runs four partial products per
// product (rate/10, elapsed*rate, division by 1e9).
// Reset: synchronous; afterwards busy stays high while both memories are swept clear.
// The result strobe cannot be stalled by the receiver.
//
// Per-flow token bucket policer, top level. Depends on pftbp_pkg.
module per_flow_token_bucket_policer #(
    parameter int FLOW_COUNT = 4096
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  pftbp_pkg::t_in  i_cmd,
    output logic            o_done,
    output pftbp_pkg::t_out o_res
);
    import pftbp_pkg::*;

    localparam int AW    = (FLOW_COUNT > 1) ? $clog2(FLOW_COUNT) : 1;
    localparam int POL_W = 1 + PRIO_W + RATE_W;
    localparam int BKT_W = 1 + TOK_W + TS_W;

    // Policy memory: {valid, priority, rate}. Bucket memory: {valid, tokens, time}.
    logic [POL_W-1:0] pol_mem [FLOW_COUNT];
    logic [BKT_W-1:0] bkt_mem [FLOW_COUNT];

    t_state            r_state, n_state;
    logic [AW-1:0]     r_clr;
    t_in               r_cmd;
    logic [POL_W-1:0]  r_pol_q;
    logic [BKT_W-1:0]  r_bkt_q;
    logic              r_done, n_done;
    t_out              r_res, n_res;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [TOK_W-1:0]  r_quo, n_quo;
    logic [TOK_W-1:0]  r_cap, n_cap;
    logic [63:0]       r_ma, n_ma;
    logic [63:0]       r_mb, n_mb;
    logic [63:0]       r_pp, n_pp;
    logic [1:0]        r_pk, n_pk;
    logic [PROD_W-1:0] r_acc, n_acc;
    logic              r_big, n_big;

    logic              accept;
    logic [AW-1:0]     acc_addr;

    // decoded fields of the registered memory words
    logic              pol_valid;
    logic [PRIO_W-1:0] pol_prio;
    logic [RATE_W-1:0] pol_rate;
    logic              bkt_valid;
    logic [TOK_W-1:0]  bkt_tok;
    logic [TS_W-1:0]   bkt_time;
    logic              idx_ok;
    logic [BITS_W-1:0] len_bits;

    // multiplier
    logic              mul_on;
    logic [1:0]        mul_k;
    logic [31:0]       mul_a, mul_b;
    logic [PROD_W-1:0] mul_add;
    logic [PROD_W-1:0] acc_sum;
    logic [TOK_W-1:0]  cap_quo;
    logic [TOK_W-1:0]  sec_quo;

    // bucket update
    logic              refill_nz;
    logic [TOK_W:0]    tok_sum;
    logic [TOK_W-1:0]  tok_fill;
    logic              upd_drop;
    logic [TOK_W-1:0]  upd_tok;
    logic [TS_W-1:0]   upd_time;

    logic              pol_we, bkt_we;
    logic [AW-1:0]     pol_wa, bkt_wa;
    logic [POL_W-1:0]  pol_wd;
    logic [BKT_W-1:0]  bkt_wd;

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign acc_addr = AW'(i_cmd.flow_index);
    assign o_done   = r_done;
    assign o_res    = r_res;

    assign pol_valid = r_pol_q[POL_W-1];
    assign pol_prio  = r_pol_q[RATE_W +: PRIO_W];
    assign pol_rate  = r_pol_q[RATE_W-1:0];
    assign bkt_valid = r_bkt_q[BKT_W-1];
    assign bkt_tok   = r_bkt_q[TS_W +: TOK_W];
    assign bkt_time  = r_bkt_q[TS_W-1:0];

    assign idx_ok   = (r_cmd.flow_index != '0) &&
                      (32'(r_cmd.flow_index) < 32'(FLOW_COUNT));
    assign len_bits = {r_cmd.packet_length, 3'b000};

    // Multiply r_ma by r_mb: one 32x32 partial product per cycle for counts 0..3, each
    // added into the accumulator in the following cycle.
    always_comb begin
        mul_on = (r_state == ST_CAP) || (r_state == ST_MUL) || (r_state == ST_DIV);
        mul_k  = r_cnt[1:0];
        mul_a  = mul_k[1] ? r_ma[63:32] : r_ma[31:0];
        mul_b  = mul_k[0] ? r_mb[63:32] : r_mb[31:0];
        case (r_pk)
            2'd0:    mul_add = {64'd0, r_pp};
            2'd3:    mul_add = {r_pp, 64'd0};
            default: mul_add = {32'd0, r_pp, 32'd0};
        endcase
        acc_sum = r_acc + mul_add;
        cap_quo = acc_sum[CAP_SHIFT +: TOK_W];
        sec_quo = acc_sum[SEC_SHIFT +: TOK_W];
    end

    // Refill, clamp to cap, then police against the packet bits; a first packet passes.
    always_comb begin
        refill_nz = r_big || (r_quo != '0);
        tok_sum   = {1'b0, bkt_tok} + {1'b0, r_quo};
        tok_fill  = (r_big || (tok_sum > {1'b0, r_cap})) ? r_cap : tok_sum[TOK_W-1:0];
        if (!bkt_valid) begin
            upd_drop = VERDICT_PASS;
            upd_tok  = r_cap - TOK_W'(len_bits);
            upd_time = r_cmd.timestamp_ns;
        end else begin
            upd_tok  = refill_nz ? tok_fill : bkt_tok;
            upd_drop = (upd_tok < TOK_W'(len_bits)) ? VERDICT_DROP : VERDICT_PASS;
            if (upd_drop == VERDICT_PASS) begin
                upd_tok = upd_tok - TOK_W'(len_bits);
            end
            upd_time = refill_nz ? r_cmd.timestamp_ns : bkt_time;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == AW'(FLOW_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (r_cmd.command == CMD_POLICY || !idx_ok || !pol_valid ||
                    pol_rate == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_CAP;
                end
            end
            ST_CAP: begin
                if (r_cnt == MUL_LAST) begin
                    n_state = bkt_valid ? ST_MUL : ST_UPD;
                end
            end
            ST_MUL: begin
                if (r_cnt == MUL_LAST) begin
                    n_state = (acc_sum >= BIG_LIM) ? ST_UPD : ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == MUL_LAST) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and result outputs.
    always_comb begin
        n_done = 1'b0;
        n_res  = r_res;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_cap  = r_cap;
        n_ma   = r_ma;
        n_mb   = r_mb;
        n_pp   = r_pp;
        n_pk   = r_pk;
        n_acc  = r_acc;
        n_big  = r_big;
        if (mul_on) begin
            n_cnt = r_cnt + 1'b1;
            if (r_cnt != MUL_LAST) begin
                n_pp = mul_a * mul_b;
                n_pk = mul_k;
            end
            if (r_cnt != '0) begin
                n_acc = acc_sum;
            end
            if (r_cnt == MUL_LAST) begin
                n_cnt = '0;
                n_acc = '0;
            end
        end
        unique case (r_state)
            ST_LOOK: begin
                n_res.verdict      = VERDICT_PASS;
                n_res.priority_set = 1'b0;
                n_res.priority_res = '0;
                if (r_cmd.command == CMD_PACKET && idx_ok && pol_valid) begin
                    n_res.priority_set = (pol_prio != '0);
                    n_res.priority_res = pol_prio;
                end
                if (r_cmd.command == CMD_POLICY || !idx_ok || !pol_valid ||
                    pol_rate == '0) begin
                    n_done = 1'b1;
                end
                // load rate/2 times the reciprocal of 5
                n_cnt = '0;
                n_acc = '0;
                n_ma  = 64'(pol_rate[RATE_W-1:1]);
                n_mb  = RCP_CAP;
            end
            ST_CAP: begin
                if (r_cnt == MUL_LAST) begin
                    n_cap = (cap_quo > TOK_W'(len_bits)) ? cap_quo : TOK_W'(len_bits);
                    n_big = 1'b0;
                    n_quo = '0;
                    // load elapsed times rate
                    n_ma  = r_cmd.timestamp_ns - bkt_time;
                    n_mb  = 64'(pol_rate);
                end
            end
            ST_MUL: begin
                if (r_cnt == MUL_LAST) begin
                    n_big = (acc_sum >= BIG_LIM);
                    // load product/2^9 times the reciprocal of 5^9
                    n_ma  = acc_sum[SEC_PRE +: 64];
                    n_mb  = RCP_SEC;
                end
            end
            ST_DIV: begin
                if (r_cnt == MUL_LAST) begin
                    n_quo = sec_quo;
                end
            end
            ST_UPD: begin
                n_done        = 1'b1;
                n_res.verdict = upd_drop;
            end
            default: begin
            end
        endcase
    end

    // Memory write ports: the reset sweep, policy writes at accept, bucket write-back.
    always_comb begin
        pol_we = 1'b0;
        pol_wa = acc_addr;
        pol_wd = {1'b1, i_cmd.new_priority, i_cmd.new_rate_bps};
        bkt_we = 1'b0;
        bkt_wa = AW'(r_cmd.flow_index);
        bkt_wd = {1'b1, upd_tok, upd_time};
        if (r_state == ST_CLEAR) begin
            pol_we = 1'b1;
            pol_wa = r_clr;
            pol_wd = '0;
            bkt_we = 1'b1;
            bkt_wa = r_clr;
            bkt_wd = '0;
        end else begin
            pol_we = accept && (i_cmd.command == CMD_POLICY) &&
                     (32'(i_cmd.flow_index) < 32'(FLOW_COUNT));
            bkt_we = (r_state == ST_UPD);
        end
    end

    always_ff @(posedge i_clk) begin
        if (pol_we) begin
            pol_mem[pol_wa] <= pol_wd;
        end
        if (accept) begin
            r_pol_q <= pol_mem[acc_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (bkt_we) begin
            bkt_mem[bkt_wa] <= bkt_wd;
        end
        if (accept) begin
            r_bkt_q <= bkt_mem[acc_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
        end
        r_res <= n_res;
        r_quo <= n_quo;
        r_cap <= n_cap;
        r_ma  <= n_ma;
        r_mb  <= n_mb;
        r_pp  <= n_pp;
        r_pk  <= n_pk;
        r_acc <= n_acc;
        r_big <= n_big;
    end

endmodule

// ----- sv/pftbp_checker.sv -----
// Port-level checker for the per-flow token bucket policer, and its bind.
// Depends on pftbp_pkg and per_flow_token_bucket_policer.
module pftbp_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            start,
    input logic            busy,
    input logic            o_done,
    input pftbp_pkg::t_out o_res
);
    import pftbp_pkg::*;

    // reset starts the clearing sweep
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy) else $error("busy low right after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("beat accepted but busy not raised");

    a_done_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result strobe while busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe held two cycles");

    a_prio_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_res.priority_set) |-> (o_res.priority_res == '0))
        else $error("priority value without priority set");

endmodule

bind per_flow_token_bucket_policer pftbp_checker u_pftbp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_res   (o_res)
);

// ----- test/tb_top.sv -----
// Testbench for the per-flow token bucket policer: directed table, then random traffic.
// Depends on pftbp_pkg and per_flow_token_bucket_policer; self-checking via a local predictor.
`timescale 1ns / 100ps

module tb_top;
    import pftbp_pkg::*;

    localparam int FLOWS        = 4096;
    localparam int RANDOM_BEATS = 500;
    localparam int DRAIN_CYCLES = 24;    // a little above the slowest refill beat
    localparam int STALL_LIMIT  = 20000; // covers the clearing sweep plus a long gap
    localparam logic [103:0] ONE_SECOND_NS = 104'd1000000000;
    localparam logic [103:0] REFILL_CEIL   = 104'd1 << 62;

    typedef struct {
        t_in  beat;
        bit   typed;    // expected result written into the row
        t_out verdict;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  i_cmd;
    logic o_done;
    t_out o_res;

    // Local copy of the flow table and the buckets.
    bit          policy_ok  [FLOWS];
    logic [31:0] policy_pri [FLOWS];
    logic [39:0] policy_bps [FLOWS];
    bit          bucket_ok  [FLOWS];
    logic [63:0] bucket_tok [FLOWS];
    logic [63:0] bucket_ts  [FLOWS];

    t_out        pending_verdicts[$];
    t_row        directed[$];
    int          errors = 0;
    int          idle_cycles = 0;
    logic [63:0] sim_now = 64'd0;
    bit          no_gaps = 1'b0;

    per_flow_token_bucket_policer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predict one beat and advance the local state the way the block does.
    function automatic t_out police(t_in b);
        t_out         r;
        logic [11:0]  f;
        logic [63:0]  bits, cap, tok, refill;
        logic [103:0] prod;
        r = '0;
        f = b.flow_index;
        if (b.command == CMD_POLICY) begin
            policy_pri[f] = b.new_priority;
            policy_bps[f] = b.new_rate_bps;
            policy_ok[f]  = 1'b1;
            return r;
        end
        // unclassified traffic and flows without policy pass untouched
        if (f == 0 || !policy_ok[f])
            return r;
        if (policy_pri[f] != 0) begin
            r.priority_set = 1'b1;
            r.priority_res = policy_pri[f];
        end
        if (policy_bps[f] == 0)
            return r;
        bits = 64'(b.packet_length) * 8;
        cap  = 64'(policy_bps[f]) / 10;
        if (cap < bits)
            cap = bits;
        // first packet of a flow: create a full bucket minus this packet
        if (!bucket_ok[f]) begin
            bucket_ok[f]  = 1'b1;
            bucket_tok[f] = cap - bits;
            bucket_ts[f]  = b.timestamp_ns;
            return r;
        end
        // exact refill; elapsed wraps modulo 2^64
        prod = {40'd0, b.timestamp_ns - bucket_ts[f]} * {64'd0, policy_bps[f]};
        prod = prod / ONE_SECOND_NS;
        refill = (prod >= REFILL_CEIL) ? 64'(REFILL_CEIL) : prod[63:0];
        tok = bucket_tok[f];
        if (refill != 0) begin
            tok = tok + refill;
            if (tok > cap)
                tok = cap;
            bucket_ts[f] = b.timestamp_ns;
        end
        if (tok < bits) begin
            bucket_tok[f] = tok;
            r.verdict = VERDICT_DROP;
        end else begin
            bucket_tok[f] = tok - bits;
        end
        return r;
    endfunction

    function automatic t_in beat(logic c, logic [11:0] f, logic [63:0] ts, logic [15:0] len,
                                 logic [31:0] pri, logic [39:0] bps);
        t_in b;
        b.command       = c;
        b.flow_index    = f;
        b.timestamp_ns  = ts;
        b.packet_length = len;
        b.new_priority  = pri;
        b.new_rate_bps  = bps;
        return b;
    endfunction

    function automatic t_out verdict_of(logic drop, logic set, logic [31:0] pri);
        t_out r;
        r.verdict      = drop;
        r.priority_set = set;
        r.priority_res = pri;
        return r;
    endfunction

    function automatic void add_row(t_in b, bit typed, t_out v);
        t_row row;
        row.beat    = b;
        row.typed   = typed;
        row.verdict = v;
        directed.push_back(row);
    endfunction

    // Mostly a handful of busy flows so buckets get hit again and again.
    function automatic t_in random_beat();
        t_in         b;
        int          r;
        logic [11:0] f;
        r = $urandom_range(0, 99);
        if (r < 85)      f = 12'($urandom_range(1, 7));
        else if (r < 93) f = 12'($urandom);
        else if (r < 96) f = 12'd0;
        else             f = 12'hFFF;
        b = beat(CMD_PACKET, f, 64'd0, 16'd0, $urandom, 40'({$urandom, $urandom}));
        b.flow_index = f;
        if ($urandom_range(0, 99) < 15) begin
            b.command = CMD_POLICY;
            if ($urandom_range(0, 3) == 0)
                b.new_priority = '0;
            r = $urandom_range(0, 99);
            if (r < 10)      b.new_rate_bps = '0;
            else if (r < 80) b.new_rate_bps = 40'($urandom_range(8000, 80000000));
            else if (r < 95) b.new_rate_bps = 40'({$urandom, $urandom});
            else             b.new_rate_bps = '1;
        end
        // advance time: mostly small steps, now and then an arbitrary jump
        r = $urandom_range(0, 99);
        if (r < 20)      sim_now = sim_now;
        else if (r < 97) sim_now = sim_now + 64'($urandom_range(1, 1000000));
        else             sim_now = {$urandom, $urandom};
        b.timestamp_ns = sim_now;
        if ($urandom_range(0, 19) == 0) b.packet_length = 16'($urandom);
        else                            b.packet_length = 16'($urandom_range(0, 200));
        return b;
    endfunction

    task automatic idle_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) n = 0;
        else if (r < 92)       n = $urandom_range(1, 3);
        else                   n = $urandom_range(10, 40);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Present one beat, hold it until accepted, then record what should come back.
    task automatic send(t_row row);
        t_out predicted;
        idle_gap();
        start <= 1'b1;
        i_cmd <= row.beat;
        do @(posedge i_clk); while (busy);
        predicted = police(row.beat);
        pending_verdicts.push_back(row.typed ? row.verdict : predicted);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %0h, want %0h", $realtime, what, got, want);
        errors++;
    endtask

    // Results cannot be held off: check every strobed beat on the edge that ends it.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("unexpected result beat", o_res.priority_res, 32'd0);
            end else begin
                want = pending_verdicts.pop_front();
                if (o_res.verdict !== want.verdict)
                    report_mismatch("verdict", 32'(o_res.verdict), 32'(want.verdict));
                if (o_res.priority_set !== want.priority_set)
                    report_mismatch("priority_set", 32'(o_res.priority_set),
                                    32'(want.priority_set));
                if (o_res.priority_res !== want.priority_res)
                    report_mismatch("priority_res", o_res.priority_res, want.priority_res);
            end
        end
    end

    // Watchdog: count cycles where neither a command nor a result beat moves.
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_done === 1'b1)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        t_row row;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_cmd   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // unclassified and unknown flows pass untouched
        add_row(beat(CMD_PACKET, 12'd0, '1, '1, '1, '1), 1, verdict_of(0, 0, 0));
        add_row(beat(CMD_PACKET, 12'hFFF, 64'd0, 16'd64, 0, 0), 1, verdict_of(0, 0, 0));
        // extremes of priority and rate on the top flow
        add_row(beat(CMD_POLICY, 12'hFFF, 64'd0, 0, '1, '1), 1, verdict_of(0, 0, 0));
        add_row(beat(CMD_PACKET, 12'hFFF, 64'd0, '1, 0, 0), 1, verdict_of(0, 1, '1));
        add_row(beat(CMD_PACKET, 12'hFFF, '1, '1, 0, 0), 0, '0);
        add_row(beat(CMD_PACKET, 12'hFFF, '1, '1, 0, 0), 0, '0);
        // zero priority and zero rate: plain pass
        add_row(beat(CMD_POLICY, 12'd1, 64'd0, 0, 0, 0), 1, verdict_of(0, 0, 0));
        add_row(beat(CMD_PACKET, 12'd1, 64'd50, '1, 0, 0), 1, verdict_of(0, 0, 0));
        // small bucket: cap 800 bits, first packet drains it
        add_row(beat(CMD_POLICY, 12'd2, 64'd0, 0, 32'd5, 40'd8000), 1, verdict_of(0, 0, 0));
        add_row(beat(CMD_PACKET, 12'd2, 64'd1000, 16'd100, 0, 0), 1, verdict_of(0, 1, 32'd5));
        // no time elapsed, no refill: drop but still report priority
        add_row(beat(CMD_PACKET, 12'd2, 64'd1000, 16'd1, 0, 0), 1, verdict_of(1, 1, 32'd5));
        add_row(beat(CMD_PACKET, 12'd2, 64'd1001000, 16'd1, 0, 0), 0, '0);
        add_row(beat(CMD_PACKET, 12'd2, 64'd1001000, 16'd0, 0, 0), 0, '0);
        // index zero accepts a policy yet its packets stay unclassified
        add_row(beat(CMD_POLICY, 12'd0, 64'd0, 0, 32'd7, 40'd100), 1, verdict_of(0, 0, 0));
        add_row(beat(CMD_PACKET, 12'd0, 64'd9, 16'd9, 0, 0), 1, verdict_of(0, 0, 0));
        // rewrite with priority zero keeps the bucket; then a timestamp that wraps
        add_row(beat(CMD_POLICY, 12'd2, 64'd0, 0, 0, 40'd8000), 1, verdict_of(0, 0, 0));
        add_row(beat(CMD_PACKET, 12'd2, 64'd5, 16'd200, 0, 0), 0, '0);
        add_row(beat(CMD_PACKET, 12'd2, 64'd5000005, 16'd1, 0, 0), 0, '0);
        // packet bigger than rate/10 sets the cap
        add_row(beat(CMD_POLICY, 12'd3, 64'd0, 0, 32'h8000_0001, 40'd80), 1,
                verdict_of(0, 0, 0));
        add_row(beat(CMD_PACKET, 12'd3, 64'd0, 16'd1500, 0, 0), 1,
                verdict_of(0, 1, 32'h8000_0001));
        add_row(beat(CMD_PACKET, 12'd3, 64'd3000000000, 16'd1, 0, 0), 0, '0);

        foreach (directed[k])
            send(directed[k]);

        row.typed = 1'b0;
        row.verdict = '0;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            // alternate stretches with and without idle gaps
            if (n % 100 == 0)
                no_gaps = ~no_gaps;
            row.beat = random_beat();
            send(row);
        end
        start <= 1'b0;

        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
